@@ sv/dmpwm_pkg.sv @@
// shared types, codes and constants for the dual motor pwm driver with speed meter
package dmpwm_pkg;

  // width of the encoder pulse counters (8 to 32)
  localparam int COUNT_WIDTH = 16;
  // phase value at which the pwm period ends (15 to 255)
  localparam int PWM_PERIOD = 255;

  localparam int PHASE_W = 8;
  localparam int SPEED_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // event codes
  localparam logic [2:0] CMD_PWM_TICK = 3'd0;
  localparam logic [2:0] CMD_PULSE_A = 3'd1;
  localparam logic [2:0] CMD_PULSE_B = 3'd2;
  localparam logic [2:0] CMD_WINDOW_TICK = 3'd3;
  localparam logic [2:0] CMD_DRIVE = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FAST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_SLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LIMIT = 3'd5;

  // command characters
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_1 = 8'h31;
  localparam logic [7:0] CHAR_2 = 8'h32;
  localparam logic [7:0] CHAR_3 = 8'h33;

  // drive pin masks
  localparam logic [3:0] PIN_FA = 4'b0001;
  localparam logic [3:0] PIN_FB = 4'b0010;
  localparam logic [3:0] PIN_RA = 4'b0100;
  localparam logic [3:0] PIN_RB = 4'b1000;

  // speed bands
  localparam logic [1:0] BAND_LOW = 2'd0;
  localparam logic [1:0] BAND_MID = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  typedef struct packed {
    logic [7:0] fast;
    logic [7:0] mid;
    logic [7:0] slow;
  } duty_cfg_t;

  typedef struct packed {
    logic [7:0]         window_ticks;
    logic [SPEED_W-1:0] low_limit;
    logic [SPEED_W-1:0] mid_limit;
  } meter_cfg_t;

  typedef struct packed {
    logic [3:0] pins;
    logic       heading;
  } drive_stat_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [1:0]         band;
  } meter_stat_t;

endpackage

@@ sv/dmpwm_drive.sv @@
// pwm phase counter, direction and duty state, and h-bridge pin update
module dmpwm_drive (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [2:0]          command,
  input  logic [7:0]          first_char,
  input  logic [7:0]          second_char,
  input  dmpwm_pkg::duty_cfg_t   duty_cfg,
  output dmpwm_pkg::drive_stat_t stat_next
);
  import dmpwm_pkg::*;

  logic [PHASE_W-1:0] pwm_phase, pwm_phase_next;
  logic               direction_flag, direction_flag_next;
  logic [7:0]         duty_a, duty_a_next;
  logic [7:0]         duty_b, duty_b_next;
  logic [3:0]         drive_pins, drive_pins_next;

  logic [PHASE_W-1:0] phase_inc;
  logic [3:0]         pa, pb;
  logic [7:0]         sel_duty;
  logic               sel_ok;

  // duty picked by the speed character
  always_comb begin
    sel_duty = '0;
    sel_ok = 1'b0;
    case (second_char)
      CHAR_1: begin
        sel_duty = duty_cfg.fast;
        sel_ok = 1'b1;
      end
      CHAR_2: begin
        sel_duty = duty_cfg.mid;
        sel_ok = 1'b1;
      end
      CHAR_3: begin
        sel_duty = duty_cfg.slow;
        sel_ok = 1'b1;
      end
      default: begin
        sel_duty = '0;
        sel_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    pwm_phase_next = pwm_phase;
    direction_flag_next = direction_flag;
    duty_a_next = duty_a;
    duty_b_next = duty_b;
    drive_pins_next = drive_pins;
    pa = direction_flag ? PIN_FA : PIN_RA;
    pb = direction_flag ? PIN_FB : PIN_RB;
    phase_inc = pwm_phase + PHASE_W'(1);
    case (command)
      CMD_PWM_TICK: begin
        if (phase_inc >= PHASE_W'(PWM_PERIOD)) begin
          pwm_phase_next = '0;
          drive_pins_next = drive_pins & ~(pa | pb);
        end else begin
          pwm_phase_next = phase_inc;
          drive_pins_next = drive_pins
                          | (phase_inc == duty_a ? pa : 4'b0000)
                          | (phase_inc == duty_b ? pb : 4'b0000);
        end
      end
      CMD_DRIVE: begin
        if (first_char == CHAR_0) begin
          direction_flag_next = 1'b1;
          drive_pins_next = drive_pins & ~(PIN_RA | PIN_RB);
          if (sel_ok) begin
            duty_a_next = sel_duty;
            duty_b_next = sel_duty;
          end else if (second_char == CHAR_0) begin
            duty_a_next = '0;
            duty_b_next = '0;
          end
        end else if (first_char == CHAR_1) begin
          // stop is ignored in reverse
          direction_flag_next = 1'b0;
          drive_pins_next = drive_pins & ~(PIN_FA | PIN_FB);
          if (sel_ok) begin
            duty_a_next = sel_duty;
            duty_b_next = sel_duty;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_next.pins = drive_pins_next;
  assign stat_next.heading = direction_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase <= '0;
      direction_flag <= 1'b1;
      duty_a <= '0;
      duty_b <= '0;
      drive_pins <= '0;
    end else if (step) begin
      pwm_phase <= pwm_phase_next;
      direction_flag <= direction_flag_next;
      duty_a <= duty_a_next;
      duty_b <= duty_b_next;
      drive_pins <= drive_pins_next;
    end
  end

  // phase wraps before reaching the period
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    pwm_phase < PHASE_W'(PWM_PERIOD))
    else $error("pwm phase reached period");

  // only pins of the current direction can be high
  a_pins_match_heading: assert property (@(posedge clk) disable iff (rst)
    (direction_flag ? (drive_pins & (PIN_RA | PIN_RB)) : (drive_pins & (PIN_FA | PIN_FB)))
      == 4'b0000)
    else $error("drive pins of the inactive direction are high");

endmodule

@@ sv/dmpwm_meter.sv @@
// encoder pulse counters, averaging window and speed band classifier
module dmpwm_meter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [2:0]            command,
  input  dmpwm_pkg::meter_cfg_t meter_cfg,
  output dmpwm_pkg::meter_stat_t stat_next
);
  import dmpwm_pkg::*;

  localparam int WIDE_W = COUNT_WIDTH + SPEED_W;

  logic [COUNT_WIDTH-1:0] pulses_a, pulses_a_next;
  logic [COUNT_WIDTH-1:0] pulses_b, pulses_b_next;
  logic [7:0]             window_count, window_count_next;
  logic [SPEED_W-1:0]     average_speed, average_speed_next;

  logic [COUNT_WIDTH:0]   pulse_sum;
  logic [WIDE_W-1:0]      avg_wide;
  logic [7:0]             window_inc;

  assign pulse_sum = {1'b0, pulses_a} + {1'b0, pulses_b};
  assign avg_wide = WIDE_W'(pulse_sum[COUNT_WIDTH:1]);
  assign window_inc = window_count + 8'd1;

  always_comb begin
    pulses_a_next = pulses_a;
    pulses_b_next = pulses_b;
    window_count_next = window_count;
    average_speed_next = average_speed;
    case (command)
      CMD_PULSE_A: begin
        if (pulses_a != '1) pulses_a_next = pulses_a + COUNT_WIDTH'(1);
      end
      CMD_PULSE_B: begin
        if (pulses_b != '1) pulses_b_next = pulses_b + COUNT_WIDTH'(1);
      end
      CMD_WINDOW_TICK: begin
        if (window_inc >= meter_cfg.window_ticks) begin
          window_count_next = '0;
          pulses_a_next = '0;
          pulses_b_next = '0;
          // saturate the average to the speed width
          if (avg_wide > WIDE_W'({SPEED_W{1'b1}})) begin
            average_speed_next = '1;
          end else begin
            average_speed_next = avg_wide[SPEED_W-1:0];
          end
        end else begin
          window_count_next = window_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_next.speed = average_speed_next;
    if (average_speed_next <= meter_cfg.low_limit) begin
      stat_next.band = BAND_LOW;
    end else if (average_speed_next <= meter_cfg.mid_limit) begin
      stat_next.band = BAND_MID;
    end else begin
      stat_next.band = BAND_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_a <= '0;
      pulses_b <= '0;
      window_count <= '0;
      average_speed <= '0;
    end else if (step) begin
      pulses_a <= pulses_a_next;
      pulses_b <= pulses_b_next;
      window_count <= window_count_next;
      average_speed <= average_speed_next;
    end
  end

endmodule

@@ sv/dual_motor_pwm_with_speed_meter_top.sv @@
// top level of the dual motor pwm driver with encoder speed meter
//
// input channel (in_valid/in_ready) carries one event per transfer: a pwm
// tick, an encoder pulse on motor a or b, a window tick, or a two-character
// drive command in first_char/second_char. every input transfer yields
// exactly one result transfer on the output channel (out_valid/out_ready)
// showing the drive pins, heading, latched speed and speed band after that
// event.
// an event passes through the input register, then the state update into the
// result register. throughput: one event per cycle while the receiver keeps
// out_ready high; the state update between the registers is combinational.
// when the receiver stalls, the result register holds and one more event
// waits in the input register; in_ready drops only when both are full.
// reset (rst, synchronous) empties both registers, clears phase, duties,
// pins, counters and speed, sets the heading to forward and loads the
// configuration registers with their defaults. configuration writes
// (cfg_we/cfg_index/cfg_data) take effect at once and are meant for idle time;
// indexes past the last register are ignored.
module dual_motor_pwm_with_speed_meter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dmpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmpwm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           command,
  input  logic [7:0]                           first_char,
  input  logic [7:0]                           second_char,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 forward_a,
  output logic                                 forward_b,
  output logic                                 reverse_a,
  output logic                                 reverse_b,
  output logic                                 heading,
  output logic [dmpwm_pkg::SPEED_W-1:0]        speed,
  output logic [1:0]                           speed_band
);
  import dmpwm_pkg::*;

  // configuration registers
  duty_cfg_t  duty_cfg;
  meter_cfg_t meter_cfg;

  // input register
  logic       s1_valid;
  logic [2:0] s1_command;
  logic [7:0] s1_first_char;
  logic [7:0] s1_second_char;

  logic        step;
  drive_stat_t drive_next;
  meter_stat_t meter_next;

  // event moves into the result register when that register is free or draining
  assign step = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_cfg.fast <= 8'd200;
      duty_cfg.mid <= 8'd125;
      duty_cfg.slow <= 8'd10;
      meter_cfg.window_ticks <= 8'd100;
      meter_cfg.low_limit <= SPEED_W'(60);
      meter_cfg.mid_limit <= SPEED_W'(93);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY_FAST: duty_cfg.fast <= cfg_data[7:0];
        REG_DUTY_MID: duty_cfg.mid <= cfg_data[7:0];
        REG_DUTY_SLOW: duty_cfg.slow <= cfg_data[7:0];
        REG_WINDOW_TICKS: meter_cfg.window_ticks <= cfg_data[7:0];
        REG_LOW_LIMIT: meter_cfg.low_limit <= cfg_data[SPEED_W-1:0];
        REG_MID_LIMIT: meter_cfg.mid_limit <= cfg_data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command <= command;
      s1_first_char <= first_char;
      s1_second_char <= second_char;
    end
  end

  dmpwm_drive u_drive (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .command     (s1_command),
    .first_char  (s1_first_char),
    .second_char (s1_second_char),
    .duty_cfg    (duty_cfg),
    .stat_next   (drive_next)
  );

  dmpwm_meter u_meter (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .command   (s1_command),
    .meter_cfg (meter_cfg),
    .stat_next (meter_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      forward_a <= |(drive_next.pins & PIN_FA);
      forward_b <= |(drive_next.pins & PIN_FB);
      reverse_a <= |(drive_next.pins & PIN_RA);
      reverse_b <= |(drive_next.pins & PIN_RB);
      heading <= drive_next.heading;
      speed <= meter_next.speed;
      speed_band <= meter_next.band;
    end
  end

  // a waiting event is never dropped while the result register is stalled
  a_hold_event: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !step) |=> s1_valid)
    else $error("pending event lost");

  // back pressure only when both registers are occupied and stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without cause");

  // a result is always registered when an event leaves the input register
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_valid && speed_band != 2'd3))
    else $error("result not registered");

endmodule

@@ tb/tb.sv @@
// testbench for the dual motor pwm driver with encoder speed meter
module tb;
  import dmpwm_pkg::*;

  // spare event codes, ignored by the block
  localparam logic [2:0] CMD_SPARE0 = 3'd5;
  localparam logic [2:0] CMD_SPARE2 = 3'd7;

  // cycle limit for the whole run before the bench stops with a timeout
  localparam int unsigned CYCLE_LIMIT = 100_000;
  // encoder pulses per motor in the streamed phase
  localparam int unsigned STREAM_PULSES = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] fc;
    logic [7:0] sc;
  } motor_event_t;

  typedef struct packed {
    logic               fa;
    logic               fb;
    logic               ra;
    logic               rb;
    logic               hd;
    logic [SPEED_W-1:0] spd;
    logic [1:0]         band;
  } motor_view_t;

  // how the sender spaces its transfers and how the receiver stalls
  typedef enum {SEND_STREAM, SEND_BURSTY, SEND_SPARSE} send_style_t;
  typedef enum {TAKE_ALWAYS, TAKE_RANDOM, TAKE_PERIODIC, TAKE_LONG_HOLDS} take_style_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           command = '0;
  logic [7:0]           first_char = '0;
  logic [7:0]           second_char = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 forward_a;
  logic                 forward_b;
  logic                 reverse_a;
  logic                 reverse_b;
  logic                 heading;
  logic [SPEED_W-1:0]   speed;
  logic [1:0]           speed_band;

  dual_motor_pwm_with_speed_meter_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .first_char  (first_char),
    .second_char (second_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .forward_a   (forward_a),
    .forward_b   (forward_b),
    .reverse_a   (reverse_a),
    .reverse_b   (reverse_b),
    .heading     (heading),
    .speed       (speed),
    .speed_band  (speed_band)
  );

  // ---------------------------------------------------------------------------
  // mirror of the motor state, advanced once per accepted input transfer
  // ---------------------------------------------------------------------------
  duty_cfg_t              duty_set  = '{fast: 8'd200, mid: 8'd125, slow: 8'd10};
  meter_cfg_t             meter_set = '{window_ticks: 8'd100, low_limit: 16'd60,
                                        mid_limit: 16'd93};
  logic [PHASE_W-1:0]     pwm_pos = '0;
  logic                   going_fwd = 1'b1;
  logic [7:0]             a_duty = '0;
  logic [7:0]             b_duty = '0;
  logic [3:0]             pin_state = '0;
  logic [COUNT_WIDTH-1:0] a_pulses = '0;
  logic [COUNT_WIDTH-1:0] b_pulses = '0;
  logic [7:0]             win_pos = '0;
  logic [SPEED_W-1:0]     speed_latch = '0;

  motor_event_t pending_events[$];   // stimulus not yet handed to the driver
  motor_view_t  due_views[$];        // predicted results not yet seen at the output

  send_style_t  send_style = SEND_BURSTY;
  take_style_t  take_style = TAKE_RANDOM;
  logic         took_item = 1'b0;    // input transfer happened at the last rising edge

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned results_seen = 0;
  int unsigned pin_results = 0;
  int unsigned settings_used = 0;
  int unsigned cmd_seen[8];
  int unsigned band_seen[4];

  // speed character picks a duty for both motors; stop only allowed going forward
  function automatic void select_duty(logic [7:0] sc, logic stop_ok);
    logic [7:0] d;
    logic       hit;
    hit = 1'b1;
    if (sc == CHAR_1) d = duty_set.fast;
    else if (sc == CHAR_2) d = duty_set.mid;
    else if (sc == CHAR_3) d = duty_set.slow;
    else if (sc == CHAR_0 && stop_ok) d = '0;
    else hit = 1'b0;
    if (hit) begin
      a_duty = d;
      b_duty = d;
    end
  endfunction

  function automatic motor_view_t advance_motor(motor_event_t ev);
    logic [3:0]        own_a;
    logic [3:0]        own_b;
    longint unsigned   avg;
    motor_view_t       v;
    case (ev.cmd)
      CMD_PWM_TICK: begin
        own_a = going_fwd ? PIN_FA : PIN_RA;
        own_b = going_fwd ? PIN_FB : PIN_RB;
        pwm_pos = pwm_pos + 1'b1;
        // end of period clears only the pins of the active direction
        if (int'(pwm_pos) >= PWM_PERIOD) begin
          pwm_pos = '0;
          pin_state = pin_state & ~(own_a | own_b);
        end else begin
          if (pwm_pos == a_duty) pin_state = pin_state | own_a;
          if (pwm_pos == b_duty) pin_state = pin_state | own_b;
        end
      end
      CMD_PULSE_A: if (a_pulses != '1) a_pulses = a_pulses + 1'b1;
      CMD_PULSE_B: if (b_pulses != '1) b_pulses = b_pulses + 1'b1;
      CMD_WINDOW_TICK: begin
        win_pos = win_pos + 1'b1;
        if (win_pos >= meter_set.window_ticks) begin
          // sum at full width, halve, then clamp to the speed width
          avg = (64'(a_pulses) + 64'(b_pulses)) >> 1;
          speed_latch = (avg > 64'hFFFF) ? 16'hFFFF : avg[15:0];
          win_pos = '0;
          a_pulses = '0;
          b_pulses = '0;
        end
      end
      CMD_DRIVE: begin
        if (ev.fc == CHAR_0) begin
          going_fwd = 1'b1;
          pin_state = pin_state & ~(PIN_RA | PIN_RB);
          select_duty(ev.sc, 1'b1);
        end else if (ev.fc == CHAR_1) begin
          going_fwd = 1'b0;
          pin_state = pin_state & ~(PIN_FA | PIN_FB);
          select_duty(ev.sc, 1'b0);
        end
      end
      default: ;
    endcase
    v.fa  = |(pin_state & PIN_FA);
    v.fb  = |(pin_state & PIN_FB);
    v.ra  = |(pin_state & PIN_RA);
    v.rb  = |(pin_state & PIN_RB);
    v.hd  = going_fwd;
    v.spd = speed_latch;
    if (speed_latch <= meter_set.low_limit) v.band = BAND_LOW;
    else if (speed_latch <= meter_set.mid_limit) v.band = BAND_MID;
    else v.band = BAND_HIGH;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_views.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: feeds pending events in bursts, holds payload until the transfer
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always @(negedge clk) begin : driver
    motor_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_item) begin
      if (gap_left != 0 || pending_events.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        ev = pending_events.pop_front();
        command     <= ev.cmd;
        first_char  <= ev.fc;
        second_char <= ev.sc;
        in_valid    <= 1'b1;
        if (burst_left != 0) burst_left--;
        // burst finished: pick the next gap and burst length
        if (burst_left == 0) begin
          case (send_style)
            SEND_STREAM: begin
              gap_left = 0;
              burst_left = 64;
            end
            SEND_BURSTY: begin
              gap_left = $urandom_range(0, 4);
              burst_left = $urandom_range(1, 12);
            end
            default: begin
              gap_left = $urandom_range(0, 15);
              burst_left = $urandom_range(1, 3);
            end
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: out_ready follows its own stall pattern
  // ---------------------------------------------------------------------------
  int unsigned stall_step = 0;
  int unsigned hold_left = 0;
  logic        hold_val = 1'b1;

  always @(negedge clk) begin : receiver
    case (take_style)
      TAKE_ALWAYS: out_ready <= 1'b1;
      TAKE_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
      TAKE_PERIODIC: begin
        out_ready <= ((stall_step % 11) >= 4);
        stall_step++;
      end
      default: begin
        // alternating long runs of ready and of stall
        if (hold_left == 0) begin
          hold_left = $urandom_range(1, 20);
          hold_val = ~hold_val;
        end
        hold_left--;
        out_ready <= hold_val;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on input transfers, checks output transfers in order
  // ---------------------------------------------------------------------------
  task automatic match_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    motor_view_t  want;
    motor_event_t ev;
    took_item <= !rst && in_valid && in_ready;
    // output side first: the result of this edge's input can not appear yet
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (due_views.size() == 0) begin
        $error("result transfer with no prediction outstanding");
        errors++;
      end else begin
        want = due_views.pop_front();
        match_field("forward_a", want.fa, forward_a);
        match_field("forward_b", want.fb, forward_b);
        match_field("reverse_a", want.ra, reverse_a);
        match_field("reverse_b", want.rb, reverse_b);
        match_field("heading", want.hd, heading);
        match_field("speed", want.spd, speed);
        match_field("speed_band", want.band, speed_band);
        if (want.fa | want.fb | want.ra | want.rb) pin_results++;
        band_seen[want.band]++;
      end
    end
    if (!rst && in_valid && in_ready) begin
      ev = '{cmd: command, fc: first_char, sc: second_char};
      cmd_seen[command]++;
      due_views.push_back(advance_motor(ev));
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_event(logic [2:0] cmd, logic [7:0] fc, logic [7:0] sc);
    pending_events.push_back('{cmd: cmd, fc: fc, sc: sc});
  endtask

  // wait until every transfer has come back, then switch the idling styles
  task automatic settle(send_style_t s, take_style_t t);
    while (pending_events.size() != 0 || in_valid || due_views.size() != 0)
      @(posedge clk);
    send_style = s;
    take_style = t;
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // program all six registers and the mirror; only called when the block is idle
  task automatic set_config(logic [7:0] fast, logic [7:0] mid, logic [7:0] slow,
                            logic [7:0] win, logic [15:0] lo, logic [15:0] hi);
    write_reg(REG_DUTY_FAST, {8'd0, fast});
    write_reg(REG_DUTY_MID, {8'd0, mid});
    write_reg(REG_DUTY_SLOW, {8'd0, slow});
    write_reg(REG_WINDOW_TICKS, {8'd0, win});
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_MID_LIMIT, hi);
    @(negedge clk);
    cfg_we <= 1'b0;
    duty_set  = '{fast: fast, mid: mid, slow: slow};
    meter_set = '{window_ticks: win, low_limit: lo, mid_limit: hi};
    settings_used++;
  endtask

  // mostly ticks and pulses so pins and bands move; drive commands mostly legal
  task automatic queue_random(int unsigned count);
    int unsigned pick;
    logic [2:0]  cmd;
    logic [7:0]  fc;
    logic [7:0]  sc;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      fc = 8'($urandom_range(0, 255));
      sc = 8'($urandom_range(0, 255));
      if (pick < 42) cmd = CMD_PWM_TICK;
      else if (pick < 57) cmd = CMD_PULSE_A;
      else if (pick < 72) cmd = CMD_PULSE_B;
      else if (pick < 82) cmd = CMD_WINDOW_TICK;
      else if (pick < 97) begin
        cmd = CMD_DRIVE;
        if ($urandom_range(0, 9) < 8) fc = $urandom_range(0, 1) ? CHAR_1 : CHAR_0;
        if ($urandom_range(0, 9) < 8) sc = CHAR_0 + 8'($urandom_range(0, 3));
      end else cmd = 3'($urandom_range(CMD_SPARE0, CMD_SPARE2));
      queue_event(cmd, fc, sc);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: tiny duties so pins rise at once, a zero-length window,
    // tight limits so all three bands show
    settle(SEND_BURSTY, TAKE_RANDOM);
    set_config(8'd1, 8'd2, 8'd255, 8'd0, 16'd0, 16'd1);
    queue_event(CMD_DRIVE, CHAR_0, CHAR_1);         // forward, fast duty
    queue_event(CMD_PWM_TICK, 8'hFF, 8'hFF);        // phase meets duty, forward pins rise
    queue_event(CMD_DRIVE, CHAR_1, CHAR_2);         // reverse clears forward pins
    queue_event(CMD_PWM_TICK, 8'h00, 8'h00);        // reverse pins rise
    queue_event(CMD_DRIVE, CHAR_1, CHAR_0);         // stop while in reverse keeps duties
    queue_event(CMD_DRIVE, 8'hFF, CHAR_1);          // bad direction, ignored
    queue_event(CMD_DRIVE, 8'h00, CHAR_3);          // bad direction, ignored
    queue_event(CMD_DRIVE, CHAR_0, 8'hFF);          // bad speed: direction only
    queue_event(CMD_DRIVE, CHAR_0, CHAR_0);         // forward stop
    queue_event(CMD_DRIVE, CHAR_1, CHAR_3);         // slow duty at the period, never fires
    queue_event(CMD_PULSE_A, 8'hFF, 8'hFF);
    queue_event(CMD_PULSE_A, 8'h00, 8'h00);
    queue_event(CMD_PULSE_B, 8'hFF, 8'h00);
    queue_event(CMD_WINDOW_TICK, 8'h00, 8'hFF);     // speed 1, middle band
    queue_event(CMD_PULSE_A, 8'h00, 8'h00);
    queue_event(CMD_PULSE_B, 8'h00, 8'h00);
    queue_event(CMD_PULSE_B, 8'hFF, 8'hFF);
    queue_event(CMD_PULSE_B, 8'h00, 8'h00);
    queue_event(CMD_WINDOW_TICK, 8'hFF, 8'hFF);     // speed 2, high band
    queue_event(CMD_WINDOW_TICK, 8'h00, 8'h00);     // empty window, low band
    queue_event(CMD_SPARE0, 8'hFF, 8'h00);
    queue_event(CMD_SPARE0 + 3'd1, 8'h00, 8'hFF);
    queue_event(CMD_SPARE2, 8'hFF, 8'hFF);
    queue_event(CMD_PWM_TICK, 8'h00, 8'h00);

    // pulses on both motors, streamed back to back
    settle(SEND_STREAM, TAKE_ALWAYS);
    set_config(8'd1, 8'd2, 8'd255, 8'd1, 16'd2, 16'd5);
    for (k = 0; k < STREAM_PULSES; k++) begin
      queue_event(CMD_PULSE_A, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      queue_event(CMD_PULSE_B, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    queue_event(CMD_WINDOW_TICK, 8'h00, 8'h00);     // speed 8, high band
    queue_event(CMD_PULSE_A, 8'hFF, 8'hFF);
    queue_event(CMD_WINDOW_TICK, 8'hFF, 8'hFF);     // back down to zero

    // random phases under different settings and idling styles
    settle(SEND_BURSTY, TAKE_RANDOM);
    set_config(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
               8'($urandom_range(1, 40)), 8'($urandom_range(1, 6)), 16'd1, 16'd4);
    queue_random(130);

    settle(SEND_SPARSE, TAKE_PERIODIC);
    set_config(8'd0, 8'd254, 8'd255, 8'd255, 16'd0, 16'hFFFF);
    queue_random(130);

    settle(SEND_STREAM, TAKE_LONG_HOLDS);
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    queue_random(130);

    settle(SEND_BURSTY, TAKE_ALWAYS);
    set_config(8'd200, 8'd125, 8'd10, 8'd100, 16'd60, 16'd93);
    queue_random(130);

    settle(SEND_SPARSE, TAKE_RANDOM);
    set_config(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)),
               8'($urandom_range(1, 20)), 8'd1, 16'd0, 16'd0);
    queue_random(130);

    // drain, then wait on to catch any stray result
    settle(SEND_BURSTY, TAKE_RANDOM);
    repeat (8) @(posedge clk);

    $display("%0d events: %0d pwm ticks, %0d pulses, %0d window ticks, %0d drive, %0d spare",
             cmd_seen.sum(), cmd_seen[CMD_PWM_TICK],
             cmd_seen[CMD_PULSE_A] + cmd_seen[CMD_PULSE_B], cmd_seen[CMD_WINDOW_TICK],
             cmd_seen[CMD_DRIVE], cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    $display("%0d results over %0d settings, %0d with a pin high, bands %0d/%0d/%0d",
             results_seen, settings_used, pin_results, band_seen[BAND_LOW],
             band_seen[BAND_MID], band_seen[BAND_HIGH]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
